// ===== src/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and constants shared by the linear probing hash table block.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int CAP_W      = 9;
	localparam int STATUS_W   = 2;
	localparam int OP_W       = 2;
	localparam int SLOT_W     = 8;
	localparam int DIGIT_W    = 8;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [CAP_W-1:0] CAP_RESET    = 9'd256;
	localparam logic [0:0]       REG_CAPACITY = 1'b0;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MARK_EMPTY   = 2'd0,
		MARK_USED    = 2'd1,
		MARK_DELETED = 2'd2
	} mark_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_HASH,
		S_HOME,
		S_PROBE,
		S_CLEAR,
		S_RESP
	} state_t;

	typedef struct packed {
		logic  mark_we;
		logic  data_we;
		mark_t mark;
	} store_wr_t;

endpackage

// ===== src/lpht_if.sv =====
// ----------------------------------------------------------------------------
// lpht_if
// Request and response channels of the hash table, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpht_req_if #(
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
);
	logic                        valid;
	logic                        ready;
	logic [lpht_pkg::OP_W-1:0]   operation;
	logic [KEY_WIDTH-1:0]        key;
	logic [VALUE_WIDTH-1:0]      value;

	modport source (output valid, output operation, output key, output value, input ready);
	modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

interface lpht_rsp_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic [lpht_pkg::STATUS_W-1:0] status;
	logic [VALUE_WIDTH-1:0]        value_out;
	logic [lpht_pkg::SLOT_W-1:0]   slot_index;

	modport source (output valid, output status, output value_out, output slot_index,
		input ready);
	modport sink   (input valid, input status, input value_out, input slot_index,
		output ready);
endinterface

// ===== src/linear_probing_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// linear_probing_hash_table_top
// Open addressing key/value table with linear probing and deleted marks.
//
//   channel  dir  handshake       words
//   req      in   valid/ready     operation, key, value
//   rsp      out  valid/ready     status, value_out, slot_index
//   apb      in   psel/penable    capacity register at byte address 0
//
// Insert, search and remove pass through the hash, home and probe states:
// the modulo unit retires eight key bits a cycle and flags its result with
// a done strobe, the home slot read is registered, and the probe loop reads
// one slot a cycle from the store. Clear sweeps all DEPTH marks of the store
// before its response. After reset the same sweep runs over every mark
// before the first word is accepted.
// A waiting response holds while the next word is accepted.
// ----------------------------------------------------------------------------
module linear_probing_hash_table_top #(
	parameter int DEPTH       = 256,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	lpht_req_if.sink                          req,
	lpht_rsp_if.source                        rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lpht_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [lpht_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lpht_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import lpht_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW = (AW > CAP_W) ? AW : CAP_W;

	state_t state_q, state_n;

	logic [CAP_W-1:0]       capacity;
	logic [CAP_W-1:0]       cap_eff;
	logic [PW-1:0]          cap_pw;

	logic                   mod_start;
	logic                   mod_done;
	logic [CAP_W-1:0]       mod_rem;
	logic [PW-1:0]          home_pw;

	logic [AW-1:0]          rd_addr;
	logic [AW-1:0]          wr_addr;
	store_wr_t              wr;
	mark_t                  rd_mark;
	logic [KEY_WIDTH-1:0]   rd_key;
	logic [VALUE_WIDTH-1:0] rd_value;

	op_t                    op_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [PW-1:0]          pos_q;
	logic [PW-1:0]          cnt_q;
	logic [AW-1:0]          sweep_q;
	logic                   sweep_last;

	status_t                res_st_q;
	logic [VALUE_WIDTH-1:0] res_val_q;
	logic [SLOT_W-1:0]      res_slot_q;

	logic                   rsp_valid_q;
	status_t                rsp_st_q;
	logic [VALUE_WIDTH-1:0] rsp_val_q;
	logic [SLOT_W-1:0]      rsp_slot_q;

	logic                   accept;
	logic                   out_free;
	logic                   load_out;

	logic [PW-1:0]          nxt_pos;
	logic                   slot_free;
	logic                   slot_match;
	logic                   probe_last;
	logic                   probe_done;
	status_t                probe_st;

	lpht_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	always_comb begin
		cap_eff = capacity;
		if (capacity == '0) begin
			cap_eff = CAP_W'(1);
		end else if (32'(capacity) > DEPTH) begin
			cap_eff = CAP_W'(DEPTH);
		end
	end

	assign cap_pw = PW'(cap_eff);

	lpht_mod #(
		.KEY_WIDTH (KEY_WIDTH)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.key     (req.key),
		.divisor (cap_eff),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	assign home_pw = PW'(mod_rem);

	lpht_store #(
		.DEPTH       (DEPTH),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH),
		.AW          (AW)
	) u_store (
		.clk      (clk),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.wr       (wr),
		.wr_key   (key_q),
		.wr_value (val_q),
		.rd_mark  (rd_mark),
		.rd_key   (rd_key),
		.rd_value (rd_value)
	);

	assign accept     = req.valid && req.ready;
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign sweep_last = (sweep_q == AW'(DEPTH - 1));

	always_comb begin
		nxt_pos    = (pos_q + PW'(1) == cap_pw) ? '0 : pos_q + PW'(1);
		slot_free  = (rd_mark != MARK_USED);
		slot_match = (rd_mark == MARK_USED) && (rd_key == key_q);
		probe_last = (cnt_q + PW'(1) == cap_pw);
		if (op_q == OP_INSERT) begin
			probe_done = slot_free || probe_last;
			probe_st   = slot_free ? ST_OK : ST_FULL;
		end else begin
			probe_done = (rd_mark == MARK_EMPTY) || slot_match || probe_last;
			probe_st   = slot_match ? ST_OK : ST_NOT_FOUND;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_INIT: begin
				if (sweep_last) state_n = S_IDLE;
			end
			S_IDLE: begin
				if (req.valid) begin
					state_n = (op_t'(req.operation) == OP_CLEAR) ? S_CLEAR : S_HASH;
				end
			end
			S_HASH: begin
				if (mod_done) state_n = S_HOME;
			end
			S_HOME: begin
				state_n = S_PROBE;
			end
			S_PROBE: begin
				if (probe_done) state_n = S_RESP;
			end
			S_CLEAR: begin
				if (sweep_last) state_n = S_RESP;
			end
			S_RESP: begin
				if (out_free) state_n = S_IDLE;
			end
			default: begin
				state_n = S_INIT;
			end
		endcase
	end

	always_comb begin
		req.ready  = 1'b0;
		mod_start  = 1'b0;
		load_out   = 1'b0;
		rd_addr    = pos_q[AW-1:0];
		wr_addr    = pos_q[AW-1:0];
		wr.mark_we = 1'b0;
		wr.data_we = 1'b0;
		wr.mark    = MARK_EMPTY;
		case (state_q)
			S_INIT, S_CLEAR: begin
				wr_addr    = sweep_q;
				wr.mark_we = 1'b1;
			end
			S_IDLE: begin
				req.ready = 1'b1;
				mod_start = req.valid && (op_t'(req.operation) != OP_CLEAR);
			end
			S_HOME: begin
				rd_addr = home_pw[AW-1:0];
			end
			S_PROBE: begin
				rd_addr = nxt_pos[AW-1:0];
				if (op_q == OP_INSERT && slot_free) begin
					wr.mark_we = 1'b1;
					wr.data_we = 1'b1;
					wr.mark    = MARK_USED;
				end else if (op_q == OP_REMOVE && slot_match) begin
					wr.mark_we = 1'b1;
					wr.mark    = MARK_DELETED;
				end
			end
			S_RESP: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			sweep_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == S_INIT || state_q == S_CLEAR) begin
				sweep_q <= sweep_q + 1'b1;
			end else if (accept) begin
				sweep_q <= '0;
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= op_t'(req.operation);
			key_q      <= req.key;
			val_q      <= req.value;
			res_st_q   <= ST_OK;
			res_val_q  <= '0;
			res_slot_q <= '0;
		end
		if (state_q == S_HOME) begin
			pos_q <= home_pw;
			cnt_q <= '0;
		end else if (state_q == S_PROBE) begin
			if (probe_done) begin
				res_st_q <= probe_st;
				if (probe_st == ST_OK) begin
					res_slot_q <= pos_q[SLOT_W-1:0];
					if (op_q == OP_SEARCH) begin
						res_val_q <= rd_value;
					end
				end
			end else begin
				pos_q <= nxt_pos;
				cnt_q <= cnt_q + PW'(1);
			end
		end
		if (load_out) begin
			rsp_st_q   <= res_st_q;
			rsp_val_q  <= res_val_q;
			rsp_slot_q <= res_slot_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_st_q;
	assign rsp.value_out  = rsp_val_q;
	assign rsp.slot_index = rsp_slot_q;

endmodule

// ===== src/lpht_regs.sv =====
// ----------------------------------------------------------------------------
// lpht_regs
// APB register file holding the capacity register.
// ----------------------------------------------------------------------------
module lpht_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lpht_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [lpht_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lpht_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	output logic [lpht_pkg::CAP_W-1:0]        capacity
);
	import lpht_pkg::*;

	logic [CAP_W-1:0] cap_q;
	logic             sel_cap;

	assign sel_cap  = (paddr[APB_ADDR_W-1:2] == REG_CAPACITY);
	assign pready   = 1'b1;
	assign capacity = cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && sel_cap) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_cap) begin
			prdata = APB_DATA_W'(cap_q);
		end
	end

endmodule

// ===== src/lpht_mod.sv =====
// ----------------------------------------------------------------------------
// lpht_mod
// Iterative key modulo capacity, one digit of the key per cycle.
// ----------------------------------------------------------------------------
module lpht_mod #(
	parameter int KEY_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [KEY_WIDTH-1:0]       key,
	input  logic [lpht_pkg::CAP_W-1:0] divisor,
	output logic                       done,
	output logic [lpht_pkg::CAP_W-1:0] rem
);
	import lpht_pkg::*;

	localparam int STEPS = (KEY_WIDTH + DIGIT_W - 1) / DIGIT_W;
	localparam int PKW   = STEPS * DIGIT_W;
	localparam int CW    = $clog2(STEPS + 1);

	logic [PKW-1:0]   sh_q;
	logic [CAP_W-1:0] rem_q;
	logic [CAP_W-1:0] rem_n;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	assign done = done_q;
	assign rem  = rem_q;

	always_comb begin
		logic [CAP_W:0]   t;
		logic [CAP_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < DIGIT_W; i++) begin
			t = {r, sh_q[PKW-1-i]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			r = t[CAP_W-1:0];
		end
		rem_n = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= PKW'(key);
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= sh_q << DIGIT_W;
			rem_q <= rem_n;
		end
	end

endmodule

// ===== src/lpht_store.sv =====
// ----------------------------------------------------------------------------
// lpht_store
// Slot memories for marks, keys and values; one write and one registered read.
// ----------------------------------------------------------------------------
module lpht_store #(
	parameter int DEPTH       = 256,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32,
	parameter int AW          = 8
) (
	input  logic                       clk,
	input  logic [AW-1:0]              rd_addr,
	input  logic [AW-1:0]              wr_addr,
	input  lpht_pkg::store_wr_t        wr,
	input  logic [KEY_WIDTH-1:0]       wr_key,
	input  logic [VALUE_WIDTH-1:0]     wr_value,
	output lpht_pkg::mark_t            rd_mark,
	output logic [KEY_WIDTH-1:0]       rd_key,
	output logic [VALUE_WIDTH-1:0]     rd_value
);
	import lpht_pkg::*;

	mark_t                  mark_mem [DEPTH];
	logic [KEY_WIDTH-1:0]   key_mem  [DEPTH];
	logic [VALUE_WIDTH-1:0] val_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.mark_we) begin
			mark_mem[wr_addr] <= wr.mark;
		end
		if (wr.data_we) begin
			key_mem[wr_addr] <= wr_key;
			val_mem[wr_addr] <= wr_value;
		end
		rd_mark  <= mark_mem[rd_addr];
		rd_key   <= key_mem[rd_addr];
		rd_value <= val_mem[rd_addr];
	end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear probing hash table. Words go in over the
// request channel, and a model of the table predicts each response. The
// responses are checked in order against those predictions. The capacity
// register is rewritten between phases, both channels idle at random, and
// one stretch of receiver hold-off fills the block until it stalls its input.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lpht_pkg::*;

	localparam int DEPTH          = 256;
	localparam int KW             = 32;
	localparam int VW             = 32;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 300;
	localparam int REPORT_LIMIT   = 10;
	localparam int POOL_SIZE      = 16;

	typedef struct {
		status_t            status;
		logic [VW-1:0]      value_out;
		logic [SLOT_W-1:0]  slot_index;
	} table_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	lpht_req_if #(.KEY_WIDTH(KW), .VALUE_WIDTH(VW)) req_ch ();
	lpht_rsp_if #(.VALUE_WIDTH(VW))                 rsp_ch ();

	linear_probing_hash_table_top #(
		.DEPTH(DEPTH),
		.KEY_WIDTH(KW),
		.VALUE_WIDTH(VW)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	mark_t            slot_mark [DEPTH];
	logic [KW-1:0]    slot_key [DEPTH];
	logic [VW-1:0]    slot_value [DEPTH];
	logic [CAP_W-1:0] capacity_reg;
	table_result_t    pending_results [$];
	logic [KW-1:0]    key_pool [POOL_SIZE];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int error_count = 0;
	int op_count [4];
	int status_count [3];

	function automatic int unsigned active_slots();
		if (capacity_reg == 0)
			return 1;
		if (capacity_reg > DEPTH)
			return DEPTH;
		return capacity_reg;
	endfunction

	function automatic int probe_for_key(logic [KW-1:0] k, int unsigned cap);
		int unsigned pos;
		int unsigned n;
		pos = k % cap;
		for (n = 0; n < cap; n++) begin
			if (slot_mark[pos] == MARK_EMPTY)
				return -1;
			if (slot_mark[pos] == MARK_USED && slot_key[pos] == k)
				return pos;
			pos = (pos + 1 == cap) ? 0 : pos + 1;
		end
		return -1;
	endfunction

	function automatic table_result_t table_step(op_t op, logic [KW-1:0] k,
			logic [VW-1:0] v);
		table_result_t r;
		int unsigned   cap;
		int unsigned   pos;
		int unsigned   n;
		int            hit;
		cap = active_slots();
		r.status = ST_OK;
		r.value_out = '0;
		r.slot_index = '0;
		case (op)
			OP_INSERT: begin
				r.status = ST_FULL;
				pos = k % cap;
				for (n = 0; n < cap; n++) begin
					if (slot_mark[pos] != MARK_USED) begin
						slot_mark[pos] = MARK_USED;
						slot_key[pos] = k;
						slot_value[pos] = v;
						r.slot_index = pos[SLOT_W-1:0];
						r.status = ST_OK;
						break;
					end
					pos = (pos + 1 == cap) ? 0 : pos + 1;
				end
			end
			OP_SEARCH: begin
				hit = probe_for_key(k, cap);
				if (hit < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.slot_index = hit[SLOT_W-1:0];
					r.value_out = slot_value[hit];
				end
			end
			OP_REMOVE: begin
				hit = probe_for_key(k, cap);
				if (hit < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.slot_index = hit[SLOT_W-1:0];
					slot_mark[hit] = MARK_DELETED;
				end
			end
			default: begin
				foreach (slot_mark[i])
					slot_mark[i] = MARK_EMPTY;
			end
		endcase
		return r;
	endfunction

	function automatic void flag_error(string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("%0t: %s", $time, msg);
	endfunction

	task automatic send_word(op_t op, logic [KW-1:0] k, logic [VW-1:0] v);
		if ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.key <= k;
		req_ch.value <= v;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(table_step(op, k, v));
		op_count[op]++;
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] c);
		wait_idle();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(4 * int'(REG_CAPACITY));
		pwdata <= APB_DATA_W'(c);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		capacity_reg = c;
	endtask

	task automatic test_directed_ops();
		send_word(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
		send_word(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(OP_INSERT, 32'd511, 32'h1234_5678);
		send_word(OP_SEARCH, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
		send_word(OP_SEARCH, 32'd511, 32'h0);
		send_word(OP_SEARCH, 32'd767, 32'h0);
		send_word(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
		send_word(OP_SEARCH, 32'd511, 32'h0);
		send_word(OP_INSERT, 32'd1023, 32'h5A5A_5A5A);
		send_word(OP_REMOVE, 32'd12345, 32'h0);
		send_word(OP_CLEAR, 32'd0, 32'h0);
		send_word(OP_SEARCH, 32'd0, 32'h0);
	endtask

	task automatic test_capacity_limits();
		write_capacity(9'd1);
		send_word(OP_INSERT, 32'd5, 32'hDEAD_BEEF);
		send_word(OP_INSERT, 32'd6, 32'h0000_0001);
		send_word(OP_SEARCH, 32'd6, 32'h0);
		send_word(OP_REMOVE, 32'd5, 32'h0);
		send_word(OP_INSERT, 32'd7, 32'h0000_0007);
		write_capacity(9'd0);
		send_word(OP_INSERT, 32'd9, 32'h0000_0009);
		write_capacity(9'd300);
		send_word(OP_INSERT, 32'd300, 32'h8000_0000);
		write_capacity(9'd4);
		send_word(OP_SEARCH, 32'd300, 32'h0);
		write_capacity(9'd511);
		send_word(OP_SEARCH, 32'd300, 32'h0);
		send_word(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_random_traffic(logic [CAP_W-1:0] cap, int count);
		logic [KW-1:0] k;
		op_t           op;
		int            pick;
		write_capacity(cap);
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 40)
				op = OP_INSERT;
			else if (pick < 70)
				op = OP_SEARCH;
			else if (pick < 98)
				op = OP_REMOVE;
			else
				op = OP_CLEAR;
			case ($urandom_range(9))
				0, 1, 2, 3, 4: k = key_pool[$urandom_range(POOL_SIZE-1)];
				5, 6:          k = KW'($urandom_range(63));
				7:             k = ~KW'($urandom_range(63));
				default:       k = $urandom;
			endcase
			if (op == OP_INSERT)
				key_pool[$urandom_range(POOL_SIZE-1)] = k;
			send_word(op, k, $urandom);
		end
	endtask

	task automatic test_backpressure();
		int i;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_capacity(9'd64);
		hold_requests++;
		for (i = 0; i < 30; i++) begin
			if (i % 3 == 2)
				send_word(OP_SEARCH, KW'(64 * (i / 2) + 3), $urandom);
			else
				send_word(OP_INSERT, KW'(64 * i + 3), $urandom);
		end
	endtask

	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		table_result_t exp_word;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				flag_error($sformatf("unexpected word: status %0d value_out %h slot %0d",
					rsp_ch.status, rsp_ch.value_out, rsp_ch.slot_index));
			end else begin
				exp_word = pending_results.pop_front();
				status_count[exp_word.status]++;
				if (rsp_ch.status !== exp_word.status
						|| rsp_ch.value_out !== exp_word.value_out
						|| rsp_ch.slot_index !== exp_word.slot_index)
					flag_error($sformatf(
						"mismatch: expected status %0d value_out %h slot %0d, got %0d %h %0d",
						exp_word.status, exp_word.value_out, exp_word.slot_index,
						rsp_ch.status, rsp_ch.value_out, rsp_ch.slot_index));
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog expired with %0d results outstanding", pending_results.size());
		$display("linear_probing_hash_table_top regression: fail");
		$finish;
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.operation = '0;
		req_ch.key = '0;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		capacity_reg = CAP_RESET;
		foreach (slot_mark[i])
			slot_mark[i] = MARK_EMPTY;
		foreach (key_pool[i])
			key_pool[i] = $urandom;
		foreach (op_count[i])
			op_count[i] = 0;
		foreach (status_count[i])
			status_count[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 7;
		rx_idle_pct = 76;
		test_directed_ops();
		test_capacity_limits();
		test_random_traffic(9'd8, 150);
		test_random_traffic(9'd3, 100);
		test_random_traffic(9'd256, 150);

		tx_idle_pct = 76;
		rx_idle_pct = 7;
		test_random_traffic(9'd16, 150);
		test_random_traffic(9'd1, 60);
		test_random_traffic(9'd255, 150);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_traffic(9'd5, 150);
		test_random_traffic(9'd32, 150);
		test_random_traffic(9'd2, 100);

		test_backpressure();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d inserts, %0d searches, %0d removes and %0d clears.",
			op_count[OP_INSERT], op_count[OP_SEARCH], op_count[OP_REMOVE],
			op_count[OP_CLEAR]);
		$display("Saw %0d done, %0d not found and %0d full; %0d errors.",
			status_count[ST_OK], status_count[ST_NOT_FOUND], status_count[ST_FULL],
			error_count);
		if (error_count == 0)
			$display("linear_probing_hash_table_top regression: pass");
		else
			$display("linear_probing_hash_table_top regression: fail");
		$finish;
	end

endmodule
